// File: hdl/aes128_cbc_block_cipher_macros.svh
// assertion macros for the aes-128 cbc block
// expects clk and rst_n in the scope of each use
`ifndef AES128_CBC_BLOCK_CIPHER_MACROS_SVH
`define AES128_CBC_BLOCK_CIPHER_MACROS_SVH

// same-cycle implication, held off during reset
`define ACBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ACBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/acbc_pkg.sv
// shared types, tables and round functions for the aes-128 cbc block
// no dependencies
`timescale 1ns / 1ps

package acbc_pkg;

  typedef logic [127:0] blk_t;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_IV_HIGH  = 2'd2,
    CFG_IV_LOW   = 2'd3
  } cfg_idx_t;

  // one round key write from the key schedule
  typedef struct packed {
    logic        we;
    logic [63:0] hi;
    logic [63:0] lo;
  } ks_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits 127-8i down
  function automatic blk_t sub_bytes(input blk_t s, input logic inv);
    blk_t o;
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
    end
    return o;
  endfunction

  function automatic blk_t shift_rows(input blk_t s, input logic inv);
    blk_t o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          o[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
        end else begin
          o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
        end
      end
    end
    return o;
  endfunction

  function automatic blk_t mix_columns(input blk_t s, input logic inv);
    blk_t o;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m4 [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = s[127-8*(4*c+r) -: 8];
        x2[r] = xtime(a[r]);
        x4[r] = xtime(x2[r]);
        x8[r] = xtime(x4[r]);
        // coefficients {2,3,1,1} forward, {14,11,13,9} inverse
        m1[r] = inv ? (x8[r] ^ x4[r] ^ x2[r]) : x2[r];
        m2[r] = inv ? (x8[r] ^ x2[r] ^ a[r])  : (x2[r] ^ a[r]);
        m3[r] = inv ? (x8[r] ^ x4[r] ^ a[r])  : a[r];
        m4[r] = inv ? (x8[r] ^ a[r])          : a[r];
      end
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*c+r) -: 8] = m1[r] ^ m2[(r+1)%4] ^ m3[(r+2)%4] ^ m4[(r+3)%4];
      end
    end
    return o;
  endfunction

endpackage

// File: hdl/acbc_if.sv
// handshake channels for blocks in and results out
// depends on nothing
`timescale 1ns / 1ps

interface acbc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        first_block;
  logic [63:0] block_high;
  logic [63:0] block_low;

  modport source (output valid, mode, first_block, block_high, block_low, input ready);
  modport sink (input valid, mode, first_block, block_high, block_low, output ready);
endinterface

interface acbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

// File: hdl/acbc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module acbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/acbc_key_sched.sv
// aes-128 key expansion, one round key per cycle written into the key rams
// depends on acbc_pkg
`timescale 1ns / 1ps

module acbc_key_sched #(
  parameter int ROUNDS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  acbc_pkg::blk_t            key,
  output acbc_pkg::ks_wr_t          wr,
  output logic [$clog2(ROUNDS+1)-1:0] waddr,
  output logic                      busy
);

  localparam int AW = $clog2(ROUNDS + 1);

  logic                busy_r, busy_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  acbc_pkg::blk_t      rk_r, rk_nxt;
  logic [7:0]          rc_r, rc_nxt;
  logic [31:0]         t;
  logic [31:0]         w0, w1, w2, w3;
  acbc_pkg::blk_t      rk_step;

  always_comb begin
    // rotate, substitute and add round constant on the last word
    t  = {acbc_pkg::SBOX[rk_r[23:16]] ^ rc_r, acbc_pkg::SBOX[rk_r[15:8]],
          acbc_pkg::SBOX[rk_r[7:0]], acbc_pkg::SBOX[rk_r[31:24]]};
    w0 = rk_r[127:96] ^ t;
    w1 = rk_r[95:64] ^ w0;
    w2 = rk_r[63:32] ^ w1;
    w3 = rk_r[31:0] ^ w2;
    rk_step = {w0, w1, w2, w3};
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rk_nxt   = rk_r;
    rc_nxt   = rc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rk_nxt   = key;
      rc_nxt   = 8'h01;
    end else if (busy_r) begin
      rk_nxt  = rk_step;
      rc_nxt  = acbc_pkg::xtime(rc_r);
      cnt_nxt = cnt_r + AW'(1);
      if (cnt_r == AW'(ROUNDS)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rk_r <= rk_nxt;
    rc_r <= rc_nxt;
  end

  assign wr.we = busy_r && !start;
  assign wr.hi = rk_r[127:64];
  assign wr.lo = rk_r[63:0];
  assign waddr = cnt_r;
  assign busy  = busy_r;

endmodule

// File: hdl/acbc_round.sv
// one aes round, forward or inverse, on the working block
// depends on acbc_pkg
`timescale 1ns / 1ps

module acbc_round (
  input  acbc_pkg::blk_t state,
  input  acbc_pkg::blk_t rk,
  input  logic           decrypt,
  input  logic           last,
  output acbc_pkg::blk_t next
);

  acbc_pkg::blk_t enc_sr, enc_mc, dec_sb, dec_ak;

  always_comb begin
    enc_sr = acbc_pkg::shift_rows(acbc_pkg::sub_bytes(state, 1'b0), 1'b0);
    enc_mc = last ? enc_sr : acbc_pkg::mix_columns(enc_sr, 1'b0);
    dec_sb = acbc_pkg::sub_bytes(acbc_pkg::shift_rows(state, 1'b1), 1'b1);
    dec_ak = dec_sb ^ rk;
    if (decrypt) begin
      next = last ? dec_ak : acbc_pkg::mix_columns(dec_ak, 1'b1);
    end else begin
      next = enc_mc ^ rk;
    end
  end

endmodule

// File: hdl/aes128_cbc_block_cipher.sv
// aes-128 cbc: the idle state takes a block and reads the first key, then come eleven round-key
// steps of the shared round unit, then the hold state loads the output; a new block is taken
// only after that load, so a result not yet taken holds the next block.
// the round keys live in two 64-bit rams read once per step; after reset and after each key
// write the schedule is rebuilt, during which no block is taken; chain and iv reset to zero
`timescale 1ns / 1ps
`include "aes128_cbc_block_cipher_macros.svh"

module aes128_cbc_block_cipher #(
  parameter int ROUNDS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  acbc_in_if.sink           in_ch,
  acbc_out_if.source        out_ch,
  input  logic              cfg_we,
  input  acbc_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]       cfg_data
);

  localparam int AW = $clog2(ROUNDS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   step_r, step_nxt;
  logic            mode_r, mode_nxt;
  acbc_pkg::blk_t  data_r, data_nxt;
  acbc_pkg::blk_t  ch_r, ch_nxt;
  acbc_pkg::blk_t  blk_r, blk_nxt;
  acbc_pkg::blk_t  chain_r, chain_nxt;
  logic            out_valid_r, out_valid_nxt;
  acbc_pkg::blk_t  out_r, out_nxt;
  logic [63:0]     key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic            kx_pend_r;

  acbc_pkg::ks_wr_t ks_wr;
  logic [AW-1:0]    ks_addr;
  logic             ks_busy;
  logic [AW-1:0]    rd_addr;
  logic [63:0]      rk_hi, rk_lo;
  acbc_pkg::blk_t   rk, round_out, in_blk, ch_in;
  logic             key_wr, in_xfer, out_free;

  // configuration registers
  assign key_wr = cfg_we && (cfg_index == acbc_pkg::CFG_KEY_HIGH ||
                             cfg_index == acbc_pkg::CFG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r  <= '0;
      key_lo_r  <= '0;
      iv_hi_r   <= '0;
      iv_lo_r   <= '0;
      kx_pend_r <= 1'b1;
    end else begin
      kx_pend_r <= key_wr;
      if (cfg_we) begin
        unique case (cfg_index)
          acbc_pkg::CFG_KEY_HIGH: key_hi_r <= cfg_data;
          acbc_pkg::CFG_KEY_LOW:  key_lo_r <= cfg_data;
          acbc_pkg::CFG_IV_HIGH:  iv_hi_r  <= cfg_data;
          acbc_pkg::CFG_IV_LOW:   iv_lo_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  acbc_key_sched #(.ROUNDS(ROUNDS)) u_key_sched (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kx_pend_r),
    .key   ({key_hi_r, key_lo_r}),
    .wr    (ks_wr),
    .waddr (ks_addr),
    .busy  (ks_busy)
  );

  acbc_ram #(.WIDTH(64), .DEPTH(ROUNDS + 1)) u_rk_hi (
    .clk (clk), .we (ks_wr.we), .waddr (ks_addr), .wdata (ks_wr.hi),
    .raddr (rd_addr), .rdata (rk_hi)
  );

  acbc_ram #(.WIDTH(64), .DEPTH(ROUNDS + 1)) u_rk_lo (
    .clk (clk), .we (ks_wr.we), .waddr (ks_addr), .wdata (ks_wr.lo),
    .raddr (rd_addr), .rdata (rk_lo)
  );

  assign rk = {rk_hi, rk_lo};

  acbc_round u_round (
    .state   (data_r),
    .rk      (rk),
    .decrypt (mode_r),
    .last    (step_r == AW'(ROUNDS)),
    .next    (round_out)
  );

  // no block while the schedule is being rebuilt
  assign in_ch.ready = (state_r == ST_IDLE) && !ks_busy && !kx_pend_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_blk      = {in_ch.block_high, in_ch.block_low};
  assign ch_in       = in_ch.first_block ? {iv_hi_r, iv_lo_r} : chain_r;

  // key address one step ahead of the round that uses it
  always_comb begin
    if (state_r == ST_RUN) begin
      if (step_r == AW'(ROUNDS)) begin
        rd_addr = '0;
      end else if (mode_r) begin
        rd_addr = AW'(ROUNDS - 1) - step_r;
      end else begin
        rd_addr = step_r + AW'(1);
      end
    end else begin
      rd_addr = in_ch.mode ? AW'(ROUNDS) : '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    mode_nxt      = mode_r;
    data_nxt      = data_r;
    ch_nxt        = ch_r;
    blk_nxt       = blk_r;
    chain_nxt     = chain_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
          mode_nxt  = in_ch.mode;
          data_nxt  = in_ch.mode ? in_blk : (in_blk ^ ch_in);
          ch_nxt    = ch_in;
          blk_nxt   = in_blk;
        end
      end
      ST_RUN: begin
        data_nxt = (step_r == '0) ? (data_r ^ rk) : round_out;
        step_nxt = step_r + AW'(1);
        if (step_r == AW'(ROUNDS)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = mode_r ? (data_r ^ ch_r) : data_r;
          chain_nxt     = mode_r ? blk_r : data_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      chain_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
    mode_r <= mode_nxt;
    data_r <= data_nxt;
    ch_r   <= ch_nxt;
    blk_r  <= blk_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_high = out_r[127:64];
  assign out_ch.result_low  = out_r[63:0];

  `ACBC_ASSERT_NEXT(a_xfer_starts_run, in_xfer, state_r == ST_RUN && step_r == '0, "transfer did not start rounds")
  `ACBC_ASSERT_NOW(a_no_run_during_ks, state_r == ST_RUN, !ks_busy && !ks_wr.we, "round keys read while schedule busy")
  `ACBC_ASSERT_NOW(a_step_in_range, state_r == ST_RUN, step_r <= AW'(ROUNDS), "round step out of range")
  `ACBC_ASSERT_NOW(a_out_from_hold, $rose(out_valid_r), $past(state_r == ST_HOLD), "result loaded outside hold")

endmodule

// File: tb/tb.sv
// testbench for the aes-128 cbc block: directed and random blocks against a built-in cbc model
// depends on acbc_pkg, acbc_in_if/acbc_out_if and aes128_cbc_block_cipher
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic        mode;
    logic        first_block;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } cbc_block_t;

  typedef struct {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } cbc_result_t;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;
  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  acbc_pkg::cfg_idx_t cfg_index;
  logic [63:0] cfg_data;

  acbc_in_if in_bus();
  acbc_out_if out_bus();

  aes128_cbc_block_cipher uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cbc_block_t  blocks_pending[$];
  cbc_result_t results_due[$];
  int          src_idle_pct;
  int          sink_stall_pct;
  int          mismatches;
  int          blocks_sent;
  int          results_seen;
  int          cycles;

  // model state
  logic [63:0]  key_hi_m, key_lo_m, iv_hi_m, iv_lo_m;
  logic [127:0] chain_m;
  logic [127:0] round_keys [11];
  logic [7:0]   inv_tab [256];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  task automatic rebuild_round_keys();
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] rc;
    logic [7:0] x;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      w[i] = key_hi_m[63-8*i -: 8];
      w[8+i] = key_lo_m[63-8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int k = 0; k < 4; k++) t[k] = w[i-4+k];
      if (i % 16 == 0) begin
        x = t[0];
        t[0] = acbc_pkg::SBOX[t[1]] ^ rc;
        t[1] = acbc_pkg::SBOX[t[2]];
        t[2] = acbc_pkg::SBOX[t[3]];
        t[3] = acbc_pkg::SBOX[x];
        rc = gf_mul(rc, 8'h02);
      end
      for (int k = 0; k < 4; k++) w[i+k] = w[i-16+k] ^ t[k];
    end
    for (int r = 0; r < 11; r++) begin
      for (int i = 0; i < 16; i++) round_keys[r][127-8*i -: 8] = w[16*r+i];
    end
  endtask

  function automatic logic [127:0] aes_round_fn(input logic [127:0] v, input logic inv,
                                                input int rnd);
    logic [7:0] s [16];
    logic [7:0] o [16];
    logic [7:0] a [4];
    logic [7:0] m [4];
    logic [7:0] acc;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
    if (!inv) begin
      for (int i = 0; i < 16; i++) s[i] = acbc_pkg::SBOX[s[i]];
      o = s;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) s[r+4*c] = o[r+4*((c+r)&3)];
      m = '{8'd2, 8'd3, 8'd1, 8'd1};
    end else begin
      o = s;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) s[r+4*((c+r)&3)] = o[r+4*c];
      for (int i = 0; i < 16; i++) s[i] = inv_tab[s[i]];
      // inverse path adds the key before mixing
      for (int i = 0; i < 16; i++) s[i] ^= round_keys[rnd][127-8*i -: 8];
      m = '{8'd14, 8'd11, 8'd13, 8'd9};
    end
    if ((!inv && rnd < 10) || (inv && rnd > 0)) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
        for (int r = 0; r < 4; r++) begin
          acc = 8'h00;
          for (int j = 0; j < 4; j++) acc ^= gf_mul(a[j], m[(j-r+4)&3]);
          s[4*c+r] = acc;
        end
      end
    end
    if (!inv)
      for (int i = 0; i < 16; i++) s[i] ^= round_keys[rnd][127-8*i -: 8];
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  function automatic cbc_result_t cbc_predict_block(input cbc_block_t b);
    logic [127:0] link;
    logic [127:0] st;
    cbc_result_t  r;
    link = b.first_block ? {iv_hi_m, iv_lo_m} : chain_m;
    if (b.mode == MODE_ENC) begin
      st = {b.block_high, b.block_low} ^ link ^ round_keys[0];
      for (int k = 1; k <= 10; k++) st = aes_round_fn(st, 1'b0, k);
      chain_m = st;
    end else begin
      st = {b.block_high, b.block_low} ^ round_keys[10];
      for (int k = 9; k >= 0; k--) st = aes_round_fn(st, 1'b1, k);
      st ^= link;
      chain_m = {b.block_high, b.block_low};
    end
    r.result_high = st[127:64];
    r.result_low = st[63:0];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (blocks_pending.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_bus.valid <= 1'b1;
        in_bus.mode <= blocks_pending[0].mode;
        in_bus.first_block <= blocks_pending[0].first_block;
        in_bus.block_high <= blocks_pending[0].block_high;
        in_bus.block_low <= blocks_pending[0].block_low;
        void'(blocks_pending.pop_front());
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // predict on input transfer, check on result transfer
  always @(posedge clk) begin
    cbc_block_t  b;
    cbc_result_t want;
    if (rst_n) begin
      out_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      if (in_bus.valid && in_bus.ready) begin
        b.mode = in_bus.mode;
        b.first_block = in_bus.first_block;
        b.block_high = in_bus.block_high;
        b.block_low = in_bus.block_low;
        results_due.push_back(cbc_predict_block(b));
        blocks_sent++;
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h_%h", out_bus.result_high, out_bus.result_low);
        end else begin
          want = results_due.pop_front();
          if (want.result_high !== out_bus.result_high
              || want.result_low !== out_bus.result_low) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %h_%h got %h_%h", results_seen,
                       want.result_high, want.result_low,
                       out_bus.result_high, out_bus.result_low);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input acbc_pkg::cfg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      acbc_pkg::CFG_KEY_HIGH: begin key_hi_m = val; rebuild_round_keys(); end
      acbc_pkg::CFG_KEY_LOW:  begin key_lo_m = val; rebuild_round_keys(); end
      acbc_pkg::CFG_IV_HIGH:  iv_hi_m = val;
      acbc_pkg::CFG_IV_LOW:   iv_lo_m = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_block(input logic md, input logic fb, input logic [63:0] hi,
                             input logic [63:0] lo);
    cbc_block_t b;
    b.mode = md;
    b.first_block = fb;
    b.block_high = hi;
    b.block_low = lo;
    blocks_pending.push_back(b);
  endtask

  // sender quiet and every result in, then room for the block to settle
  task automatic wait_drained();
    while (blocks_pending.size() > 0 || in_bus.valid || results_due.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly proper messages: first block then chained ones, some noise
  task automatic queue_messages(input int n);
    int   len;
    logic md;
    int   cnt;
    cnt = 0;
    while (cnt < n) begin
      len = $urandom_range(1, 8);
      md = logic'($urandom_range(0, 1));
      for (int k = 0; k < len; k++) begin
        queue_block(($urandom_range(0, 9) == 0) ? logic'($urandom_range(0, 1)) : md,
                    ($urandom_range(0, 9) == 0) ? logic'($urandom_range(0, 1)) : (k == 0),
                    rand64(), rand64());
        cnt++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = acbc_pkg::CFG_KEY_HIGH;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_ENC;
    in_bus.first_block = 1'b0;
    in_bus.block_high = '0;
    in_bus.block_low = '0;
    out_bus.ready = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    mismatches = 0;
    blocks_sent = 0;
    results_seen = 0;
    cycles = 0;
    for (int i = 0; i < 256; i++) inv_tab[acbc_pkg::SBOX[i]] = i[7:0];
    key_hi_m = '0;
    key_lo_m = '0;
    iv_hi_m = '0;
    iv_lo_m = '0;
    chain_m = '0;
    rebuild_round_keys();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero key from reset, chaining before any first block, mixed modes
    queue_block(MODE_ENC, 1'b0, '0, '0);
    queue_block(MODE_ENC, 1'b0, '1, '1);
    queue_block(MODE_DEC, 1'b0, '0, '1);
    queue_block(MODE_ENC, 1'b1, '0, '0);
    queue_block(MODE_DEC, 1'b1, '1, '0);
    wait_drained();
    write_reg(acbc_pkg::CFG_KEY_HIGH, '1);
    write_reg(acbc_pkg::CFG_KEY_LOW, '1);
    write_reg(acbc_pkg::CFG_IV_HIGH, '1);
    write_reg(acbc_pkg::CFG_IV_LOW, '1);
    queue_block(MODE_ENC, 1'b1, '0, '0);
    queue_block(MODE_ENC, 1'b0, '1, '1);
    queue_block(MODE_DEC, 1'b0, '1, '1);
    queue_block(MODE_DEC, 1'b1, '0, '0);
    queue_block(MODE_ENC, 1'b0, 64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef);
    wait_drained();
    // iv change seen only by a first block; key change leaves the chain alone
    write_reg(acbc_pkg::CFG_IV_HIGH, 64'h0011_2233_4455_6677);
    write_reg(acbc_pkg::CFG_IV_LOW, '0);
    queue_block(MODE_ENC, 1'b0, rand64(), rand64());
    queue_block(MODE_ENC, 1'b1, rand64(), rand64());
    wait_drained();
    write_reg(acbc_pkg::CFG_KEY_HIGH, 64'h2b7e_1516_28ae_d2a6);
    write_reg(acbc_pkg::CFG_KEY_LOW, 64'habf7_1588_09cf_4f3c);
    queue_block(MODE_DEC, 1'b0, rand64(), rand64());
    queue_block(MODE_ENC, 1'b0, rand64(), rand64());
    queue_block(MODE_DEC, 1'b1, rand64(), rand64());
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
        default: begin src_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      case (ph)
        0: begin
          write_reg(acbc_pkg::CFG_KEY_HIGH, '0);
          write_reg(acbc_pkg::CFG_KEY_LOW, '0);
          write_reg(acbc_pkg::CFG_IV_HIGH, '0);
          write_reg(acbc_pkg::CFG_IV_LOW, '0);
        end
        1: begin
          write_reg(acbc_pkg::CFG_KEY_HIGH, '1);
          write_reg(acbc_pkg::CFG_KEY_LOW, '0);
          write_reg(acbc_pkg::CFG_IV_HIGH, '0);
          write_reg(acbc_pkg::CFG_IV_LOW, '1);
        end
        5: write_reg(acbc_pkg::CFG_KEY_LOW, rand64());
        default: begin
          write_reg(acbc_pkg::CFG_KEY_HIGH, rand64());
          write_reg(acbc_pkg::CFG_KEY_LOW, rand64());
          write_reg(acbc_pkg::CFG_IV_HIGH, rand64());
          write_reg(acbc_pkg::CFG_IV_LOW, rand64());
        end
      endcase
      queue_messages(105);
      // the second batch is queued only once every result is back
      while (blocks_pending.size() > 0 || in_bus.valid || results_due.size() > 0)
        @(posedge clk);
      queue_messages(105);
      wait_drained();
    end

    repeat (30) @(posedge clk);
    $display("%0d blocks in, %0d results out: encrypt/decrypt chains, iv and key changes,",
             blocks_sent, results_seen);
    $display("extreme and random keys under four idling patterns, %0d mismatches", mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/acbc_pkg.sv
hdl/acbc_if.sv
hdl/acbc_ram.sv
hdl/acbc_key_sched.sv
hdl/acbc_round.sv
hdl/aes128_cbc_block_cipher.sv
tb/tb.sv
